// File: rtl/core/owbm_pkg.sv
// Shared types and constants for the single-wire bus master.
// Holds command codes, queued item format, phase and drive encodings,
// and the register map; used by every module of the block.
package owbm_pkg;

    // Command codes as they arrive on the input stream
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Line drive codes on the result stream
    localparam logic [1:0] DRV_REL  = 2'd0;
    localparam logic [1:0] DRV_LOW  = 2'd1;
    localparam logic [1:0] DRV_HIGH = 2'd2;

    // Register map
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;
    localparam int TIMER_W = 10;

    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESENCE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ONE_LOW      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SLOT_HOLD    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SLOT_RECOVER = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_READ_LOW     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd7;

    localparam logic [TIMER_W-1:0] DEF_RESET_LOW    = 10'd480;
    localparam logic [TIMER_W-1:0] DEF_PRESENCE     = 10'd70;
    localparam logic [TIMER_W-1:0] DEF_RESET_TAIL   = 10'd410;
    localparam logic [TIMER_W-1:0] DEF_ONE_LOW      = 10'd10;
    localparam logic [TIMER_W-1:0] DEF_SLOT_HOLD    = 10'd55;
    localparam logic [TIMER_W-1:0] DEF_SLOT_RECOVER = 10'd5;
    localparam logic [TIMER_W-1:0] DEF_READ_LOW     = 10'd3;
    localparam logic [TIMER_W-1:0] DEF_READ_SAMPLE  = 10'd10;

    // Fixed wait after a read sample
    localparam logic [TIMER_W-1:0] RD_TAIL_TICKS = 10'd53;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_RESET,
        OP_WRITE,
        OP_READ
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  wval;
        logic        level;
    } item_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_WR_LOW,
        PH_WR_HOLD,
        PH_WR_RECOVER,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_TAIL
    } phase_t;

endpackage

// File: rtl/core/one_wire_bus_master.sv
// Top level of the single-wire bus master: front end with command queue
// and back end with sequencer and result register.
// Depends on owbm_pkg, owbm_front and owbm_back.

// Each input beat is a one-microsecond tick or a reset, write-byte or
// read-byte command, and yields exactly one result beat giving the line
// drive, busy, done, presence level, last read byte and a rejected flag
// (command while busy). One beat is accepted per clock while the queue has
// room. Accepted beats go into the front queue; the back end pops one when
// the result register is free or being drained and registers its result
// there, raising m_tvalid. The two-entry queue plus the result register
// hold three beats, so input keeps flowing for a while when the output is
// stalled. Timing registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no beat is in flight; the block does not enforce this.
module one_wire_bus_master
    import owbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [TIMER_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [7:0] write_value, [8] line_level, [15:9] zero
    input  logic [1:0]           s_tuser,   // [1:0] cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata    // [1:0] line_drive, [2] busy_res, [3] done_res,
                                            // [4] presence_missing, [12:5] read_data,
                                            // [13] rejected, [15:14] zero
);

    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    owbm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    owbm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/core/owbm_front.sv
// Front end of the bus master: accepts input beats, classifies the command
// and holds the classified items in a short queue for the back end.
// Depends on owbm_pkg.
module owbm_front
    import owbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] write_value, [8] line_level, [15:9] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t                  items_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push;
    item_t                  in_item;

    // Classify the incoming command
    always_comb
    begin
        in_item.wval  = s_tdata[7:0];
        in_item.level = s_tdata[8];
        unique case (s_tuser)
            CMD_TICK:  in_item.kind = OP_TICK;
            CMD_RESET: in_item.kind = OP_RESET;
            CMD_WRITE: in_item.kind = OP_WRITE;
            CMD_READ:  in_item.kind = OP_READ;
            default:   in_item.kind = OP_TICK;
        endcase
    end

    assign s_tready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = items_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            items_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/core/owbm_back.sv
// Back end of the bus master: timing registers, phase sequencer and the
// result output register. Takes classified items from the front queue.
// Depends on owbm_pkg.
module owbm_back
    import owbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [TIMER_W-1:0]   cfg_data,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata
);

    logic [TIMER_W-1:0] regs_reg [NUM_REGS];

    phase_t             phase_reg, phase_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [2:0]         bit_idx_reg, bit_idx_next;
    logic [7:0]         shift_reg, shift_next;
    logic               presence_reg, presence_next;
    logic [7:0]         rdata_reg, rdata_next;

    logic               out_valid_reg;
    logic [15:0]        out_data_reg;

    logic               done;
    logic               rej;
    logic [1:0]         drive;

    // Timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[REG_RESET_LOW]    <= DEF_RESET_LOW;
            regs_reg[REG_PRESENCE]     <= DEF_PRESENCE;
            regs_reg[REG_RESET_TAIL]   <= DEF_RESET_TAIL;
            regs_reg[REG_ONE_LOW]      <= DEF_ONE_LOW;
            regs_reg[REG_SLOT_HOLD]    <= DEF_SLOT_HOLD;
            regs_reg[REG_SLOT_RECOVER] <= DEF_SLOT_RECOVER;
            regs_reg[REG_READ_LOW]     <= DEF_READ_LOW;
            regs_reg[REG_READ_SAMPLE]  <= DEF_READ_SAMPLE;
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    // Take an item whenever the output slot is free or being drained
    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    // Sequencer: next phase, timer and data path for the popped item
    always_comb
    begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        bit_idx_next  = bit_idx_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        rdata_next    = rdata_reg;
        done          = 1'b0;
        rej           = 1'b0;

        if (q_pop)
        begin
            if (q_item.kind == OP_TICK)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next = PH_IDLE;
                end
                else if (timer_reg > TIMER_W'(1))
                begin
                    timer_next = timer_reg - 1'b1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_RST_LOW:
                        begin
                            phase_next = PH_RST_WAIT;
                            timer_next = regs_reg[REG_PRESENCE];
                        end
                        PH_RST_WAIT:
                        begin
                            presence_next = q_item.level;
                            phase_next    = PH_RST_TAIL;
                            timer_next    = regs_reg[REG_RESET_TAIL];
                        end
                        PH_RST_TAIL:
                        begin
                            phase_next = PH_IDLE;
                            timer_next = '0;
                            done       = 1'b1;
                        end
                        PH_WR_LOW:
                        begin
                            phase_next = PH_WR_HOLD;
                            timer_next = regs_reg[REG_SLOT_HOLD];
                        end
                        PH_WR_HOLD:
                        begin
                            phase_next = PH_WR_RECOVER;
                            timer_next = regs_reg[REG_SLOT_RECOVER];
                        end
                        PH_WR_RECOVER:
                        begin
                            shift_next = {1'b0, shift_reg[7:1]};
                            if (bit_idx_reg == 3'd7)
                            begin
                                bit_idx_next = '0;
                                phase_next   = PH_IDLE;
                                timer_next   = '0;
                                done         = 1'b1;
                            end
                            else
                            begin
                                bit_idx_next = bit_idx_reg + 1'b1;
                                phase_next   = PH_WR_LOW;
                                timer_next   = regs_reg[REG_ONE_LOW];
                            end
                        end
                        PH_RD_LOW:
                        begin
                            phase_next = PH_RD_WAIT;
                            timer_next = regs_reg[REG_READ_SAMPLE];
                        end
                        PH_RD_WAIT:
                        begin
                            shift_next = {q_item.level, shift_reg[7:1]};
                            phase_next = PH_RD_TAIL;
                            timer_next = RD_TAIL_TICKS;
                        end
                        PH_RD_TAIL:
                        begin
                            if (bit_idx_reg == 3'd7)
                            begin
                                bit_idx_next = '0;
                                rdata_next   = shift_reg;
                                phase_next   = PH_IDLE;
                                timer_next   = '0;
                                done         = 1'b1;
                            end
                            else
                            begin
                                bit_idx_next = bit_idx_reg + 1'b1;
                                phase_next   = PH_RD_LOW;
                                timer_next   = regs_reg[REG_READ_LOW];
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                bit_idx_next = '0;
                unique case (q_item.kind)
                    OP_RESET:
                    begin
                        phase_next = PH_RST_LOW;
                        timer_next = regs_reg[REG_RESET_LOW];
                    end
                    OP_WRITE:
                    begin
                        shift_next = q_item.wval;
                        phase_next = PH_WR_LOW;
                        timer_next = regs_reg[REG_ONE_LOW];
                    end
                    default:
                    begin
                        shift_next = '0;
                        phase_next = PH_RD_LOW;
                        timer_next = regs_reg[REG_READ_LOW];
                    end
                endcase
            end
        end
    end

    // Line drive for the phase after this item
    always_comb
    begin
        unique case (phase_next)
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drive = DRV_LOW;
            PH_WR_HOLD:    drive = shift_next[0] ? DRV_HIGH : DRV_LOW;
            PH_WR_RECOVER: drive = DRV_HIGH;
            default:       drive = DRV_REL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            bit_idx_reg   <= '0;
            shift_reg     <= '0;
            presence_reg  <= 1'b1;
            rdata_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            bit_idx_reg  <= bit_idx_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            rdata_reg    <= rdata_next;
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= {2'b00, rej, rdata_next, presence_next, done,
                             (phase_next != PH_IDLE), drive};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
